>>> sv/tdsm_pkg.sv
// tdsm_pkg: shared constants for the table-driven state machine unit.
// Holds default sizes, field widths, opcode and status codes.
// No dependencies.
package tdsm_pkg;

    // Default sizes
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int STATE_WIDTH_DEF = 8;
    localparam int EVENT_WIDTH_DEF = 8;

    // Fixed port field widths
    localparam int OPCODE_W    = 2;
    localparam int FIELD_W     = 8;
    localparam int STATE_CNT_W = 9;
    localparam int STATUS_W    = 2;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SET  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FIRE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

endpackage

>>> sv/tdsm_ram.sv
// tdsm_ram: generic single-write, single-read RAM with registered read data.
// Width and depth are parameters. No dependencies.
module tdsm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/table_driven_state_machine_unit.sv
// Table-driven state machine unit: transition table in tdsm_ram, state in registers.
// Add, set_state and unused opcodes go from accept to the done state, then to the output register;
// a fire word first scans the table from entry 0 until a match or the last written entry.
// Words do not overlap: in_stall holds the input until the result is loaded into the output register;
// the scan reads one table entry per cycle through the single RAM read port.
// Reset (rst_n, async low) clears state, entry count, state count and handshakes.
module table_driven_state_machine_unit #(
    parameter int TABLE_DEPTH = tdsm_pkg::TABLE_DEPTH_DEF,
    parameter int STATE_WIDTH = tdsm_pkg::STATE_WIDTH_DEF,
    parameter int EVENT_WIDTH = tdsm_pkg::EVENT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tdsm_pkg::STATE_CNT_W-1:0]  cfg_data,
    // Input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tdsm_pkg::OPCODE_W-1:0]     opcode,
    input  logic [tdsm_pkg::FIELD_W-1:0]      from_state,
    input  logic [tdsm_pkg::FIELD_W-1:0]      to_state,
    input  logic [tdsm_pkg::FIELD_W-1:0]      event_code,
    // Output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tdsm_pkg::FIELD_W-1:0]      current_state,
    output logic                              fired,
    output logic [tdsm_pkg::STATUS_W-1:0]     status
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = AW + 1;
    localparam int ENT_W = 2 * STATE_WIDTH + EVENT_WIDTH;
    localparam int CMPW  = (STATE_WIDTH > tdsm_pkg::STATE_CNT_W) ? STATE_WIDTH
                                                                 : tdsm_pkg::STATE_CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } fsm_t;

    fsm_t                             st_reg;
    logic [STATE_WIDTH-1:0]           cur_state_reg;
    logic [CW-1:0]                    entry_count_reg;
    logic [tdsm_pkg::STATE_CNT_W-1:0] state_count_reg;
    logic [AW-1:0]                    scan_idx_reg;
    logic [EVENT_WIDTH-1:0]           fire_ev_reg;
    logic                             pend_fired_reg;
    logic [tdsm_pkg::STATUS_W-1:0]    pend_status_reg;
    logic                             out_valid_reg;
    logic [tdsm_pkg::FIELD_W-1:0]     out_state_reg;
    logic                             out_fired_reg;
    logic [tdsm_pkg::STATUS_W-1:0]    out_status_reg;

    logic                   accept;
    logic                   out_take;
    logic                   out_load;
    logic                   full;
    logic [STATE_WIDTH-1:0] src_in;
    logic [STATE_WIDTH-1:0] dst_in;
    logic [EVENT_WIDTH-1:0] ev_in;
    logic                   set_ok;
    logic [CW-1:0]          next_ext;
    logic                   scan_more;
    logic [ENT_W-1:0]       rd_data;
    logic [STATE_WIDTH-1:0] ent_src;
    logic [STATE_WIDTH-1:0] ent_dst;
    logic [EVENT_WIDTH-1:0] ent_ev;
    logic                   ent_match;
    logic                   ram_wr_en;
    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign in_stall  = (st_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_load  = (st_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Input fields reduced to the configured widths
    assign src_in = STATE_WIDTH'(from_state);
    assign dst_in = STATE_WIDTH'(to_state);
    assign ev_in  = EVENT_WIDTH'(event_code);
    assign full   = (entry_count_reg == DEPTH_C);
    assign set_ok = (CMPW'(dst_in) < CMPW'(state_count_reg));

    // Table entry unpack and match against current state and fired event
    assign ent_src   = rd_data[ENT_W-1 -: STATE_WIDTH];
    assign ent_dst   = rd_data[EVENT_WIDTH +: STATE_WIDTH];
    assign ent_ev    = rd_data[EVENT_WIDTH-1:0];
    assign ent_match = (ent_src == cur_state_reg) && (ent_ev == fire_ev_reg);

    // Next scan index and whether any written entry remains past it
    assign next_ext  = {1'b0, scan_idx_reg} + CW'(1);
    assign scan_more = (next_ext < entry_count_reg);

    // RAM control: append on add, prefetch entry 0 on fire, then one per cycle
    always_comb
    begin
        ram_wr_en   = accept && (opcode == tdsm_pkg::OP_ADD) && !full;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        case (st_reg)
            ST_IDLE:
            begin
                ram_rd_en   = accept && (opcode == tdsm_pkg::OP_FIRE)
                              && (entry_count_reg != '0);
                ram_rd_addr = '0;
            end
            ST_SCAN:
            begin
                ram_rd_en   = !ent_match && scan_more;
                ram_rd_addr = next_ext[AW-1:0];
            end
            default:
            begin
                ram_rd_en   = 1'b0;
                ram_rd_addr = '0;
            end
        endcase
    end

    tdsm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (entry_count_reg[AW-1:0]),
        .wr_data ({src_in, dst_in, ev_in}),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer, state registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= ST_IDLE;
            cur_state_reg   <= '0;
            entry_count_reg <= '0;
            state_count_reg <= '0;
            scan_idx_reg    <= '0;
            fire_ev_reg     <= '0;
            pend_fired_reg  <= 1'b0;
            pend_status_reg <= tdsm_pkg::STATUS_OK;
            out_valid_reg   <= 1'b0;
            out_state_reg   <= '0;
            out_fired_reg   <= 1'b0;
            out_status_reg  <= tdsm_pkg::STATUS_OK;
        end
        else
        begin
            if (cfg_valid)
            begin
                state_count_reg <= cfg_data;
            end

            case (st_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pend_fired_reg <= 1'b0;
                        case (opcode)
                            tdsm_pkg::OP_ADD:
                            begin
                                st_reg <= ST_DONE;
                                if (full)
                                begin
                                    pend_status_reg <= tdsm_pkg::STATUS_FULL;
                                end
                                else
                                begin
                                    pend_status_reg <= tdsm_pkg::STATUS_OK;
                                    entry_count_reg <= entry_count_reg + CW'(1);
                                end
                            end
                            tdsm_pkg::OP_SET:
                            begin
                                st_reg <= ST_DONE;
                                if (set_ok)
                                begin
                                    pend_status_reg <= tdsm_pkg::STATUS_OK;
                                    cur_state_reg   <= dst_in;
                                end
                                else
                                begin
                                    pend_status_reg <= tdsm_pkg::STATUS_RANGE;
                                end
                            end
                            tdsm_pkg::OP_FIRE:
                            begin
                                pend_status_reg <= tdsm_pkg::STATUS_OK;
                                fire_ev_reg     <= ev_in;
                                scan_idx_reg    <= '0;
                                if (entry_count_reg != '0)
                                begin
                                    st_reg <= ST_SCAN;
                                end
                                else
                                begin
                                    st_reg <= ST_DONE;
                                end
                            end
                            default:
                            begin
                                // unused opcode: no change, ok status
                                pend_status_reg <= tdsm_pkg::STATUS_OK;
                                st_reg          <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (ent_match)
                    begin
                        cur_state_reg  <= ent_dst;
                        pend_fired_reg <= 1'b1;
                        st_reg         <= ST_DONE;
                    end
                    else if (scan_more)
                    begin
                        scan_idx_reg <= next_ext[AW-1:0];
                    end
                    else
                    begin
                        st_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        st_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase

            // Output register: load a finished word, drop it once taken
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_state_reg  <= tdsm_pkg::FIELD_W'(cur_state_reg);
                out_fired_reg  <= pend_fired_reg;
                out_status_reg <= pend_status_reg;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign current_state = out_state_reg;
    assign fired         = out_fired_reg;
    assign status        = out_status_reg;

`ifndef SYNTHESIS
    // Entry count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= DEPTH_C)
        else $error("entry count beyond table depth");

    // The scan only looks at written entries
    a_scan_written: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_SCAN) |-> ({1'b0, scan_idx_reg} < entry_count_reg))
        else $error("scan index past written entries");

    // An accepted add into a table with room appends exactly one entry
    a_add_append: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == tdsm_pkg::OP_ADD) && !full)
        |=> (entry_count_reg == $past(entry_count_reg) + CW'(1)))
        else $error("add did not append one entry");

    // A fired word always reports ok status
    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fired_reg) |-> (out_status_reg == tdsm_pkg::STATUS_OK))
        else $error("fired word with non-ok status");
`endif

endmodule

>>> dv/testbench.sv
// Self-checking testbench for table_driven_state_machine_unit.
// Depends on tdsm_pkg and the unit; predicts each result word in-line and
// compares it against the output channel under random idling and stalls.
`timescale 1ns / 1ps

module testbench;

    localparam logic [tdsm_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int DEPTH      = tdsm_pkg::TABLE_DEPTH_DEF;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 80;

    typedef struct packed {
        logic [tdsm_pkg::FIELD_W-1:0]  state;
        logic                          fired;
        logic [tdsm_pkg::STATUS_W-1:0] status;
    } fsm_result_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [tdsm_pkg::STATE_CNT_W-1:0] cfg_data;
    logic                             in_valid;
    logic                             in_stall;
    logic [tdsm_pkg::OPCODE_W-1:0]    opcode;
    logic [tdsm_pkg::FIELD_W-1:0]     from_state;
    logic [tdsm_pkg::FIELD_W-1:0]     to_state;
    logic [tdsm_pkg::FIELD_W-1:0]     event_code;
    logic                             out_valid;
    logic                             out_stall;
    logic [tdsm_pkg::FIELD_W-1:0]     current_state;
    logic                             fired;
    logic [tdsm_pkg::STATUS_W-1:0]    status;

    // Predicted machine: transition table, entry count, state, state count
    logic [tdsm_pkg::FIELD_W-1:0]     tbl_src [DEPTH];
    logic [tdsm_pkg::FIELD_W-1:0]     tbl_dst [DEPTH];
    logic [tdsm_pkg::FIELD_W-1:0]     tbl_ev  [DEPTH];
    int                               tbl_count;
    logic [tdsm_pkg::FIELD_W-1:0]     fsm_state;
    logic [tdsm_pkg::STATE_CNT_W-1:0] defined_states;

    fsm_result_t expected_results[$];
    int          error_count;

    // Idling knobs, percent chance per word / per cycle
    int gap_pct;
    int stall_pct;
    bit hold_request;

    table_driven_state_machine_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .from_state    (from_state),
        .to_state      (to_state),
        .event_code    (event_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .current_state (current_state),
        .fired         (fired),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Apply one accepted word to the predicted machine and queue its result
    function automatic void predict_fsm_step(input logic [tdsm_pkg::OPCODE_W-1:0] op,
                                             input logic [tdsm_pkg::FIELD_W-1:0] src,
                                             input logic [tdsm_pkg::FIELD_W-1:0] dst,
                                             input logic [tdsm_pkg::FIELD_W-1:0] ev);
        fsm_result_t res;
        res.fired  = 1'b0;
        res.status = tdsm_pkg::STATUS_OK;
        if (op == tdsm_pkg::OP_ADD)
        begin
            if (tbl_count < DEPTH)
            begin
                tbl_src[tbl_count] = src;
                tbl_dst[tbl_count] = dst;
                tbl_ev[tbl_count]  = ev;
                tbl_count++;
            end
            else
                res.status = tdsm_pkg::STATUS_FULL;
        end
        else if (op == tdsm_pkg::OP_SET)
        begin
            if ({1'b0, dst} < defined_states)
                fsm_state = dst;
            else
                res.status = tdsm_pkg::STATUS_RANGE;
        end
        else if (op == tdsm_pkg::OP_FIRE)
        begin
            // first matching entry in insertion order wins
            for (int i = 0; i < tbl_count; i++)
            begin
                if (tbl_src[i] == fsm_state && tbl_ev[i] == ev)
                begin
                    fsm_state = tbl_dst[i];
                    res.fired = 1'b1;
                    break;
                end
            end
        end
        res.state = fsm_state;
        expected_results = {expected_results, res};
    endfunction

    // Mostly a small set of states/events so transitions actually match
    function automatic logic [tdsm_pkg::FIELD_W-1:0] rand_field();
        if ($urandom_range(4) != 0)
            return tdsm_pkg::FIELD_W'($urandom_range(15));
        return tdsm_pkg::FIELD_W'($urandom_range(255));
    endfunction

    // Prefer an event that leaves the current state, if the table has one
    function automatic logic [tdsm_pkg::FIELD_W-1:0] pick_fire_event();
        logic [tdsm_pkg::FIELD_W-1:0] hits[$];
        for (int i = 0; i < tbl_count; i++)
            if (tbl_src[i] == fsm_state)
                hits = {hits, tbl_ev[i]};
        if (hits.size() > 0 && $urandom_range(3) != 0)
            return hits[$urandom_range(hits.size() - 1)];
        return rand_field();
    endfunction

    // Sender gap: mostly short, sometimes long
    task automatic idle_gap();
        int len;
        if ($urandom_range(99) < gap_pct)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            repeat (len) @(negedge clk);
        end
    endtask

    // Send one word; entered and left at a falling edge
    task automatic send_word(input logic [tdsm_pkg::OPCODE_W-1:0] op,
                             input logic [tdsm_pkg::FIELD_W-1:0] src,
                             input logic [tdsm_pkg::FIELD_W-1:0] dst,
                             input logic [tdsm_pkg::FIELD_W-1:0] ev);
        in_valid   = 1'b1;
        opcode     = op;
        from_state = src;
        to_state   = dst;
        event_code = ev;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_fsm_step(op, src, dst, ev);
        @(negedge clk);
        in_valid = 1'b0;
        idle_gap();
    endtask

    task automatic wait_all_results();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Register write, only with nothing in flight
    task automatic write_state_count(input logic [tdsm_pkg::STATE_CNT_W-1:0] value);
        wait_all_results();
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        defined_states = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold on request
    initial
    begin : out_stall_gen
        int hold_left;
        int run_left;
        hold_left = 0;
        run_left  = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (run_left > 0)
            begin
                out_stall = 1'b1;
                run_left--;
            end
            else if ($urandom_range(99) < stall_pct)
            begin
                out_stall = 1'b1;
                run_left  = ($urandom_range(9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
            end
            else
                out_stall = 1'b0;
        end
    end

    // Result checker
    always @(posedge clk)
    begin : check_result
        fsm_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result word: state %0d fired %0d status %0d",
                         $time, current_state, fired, status);
            end
            else
            begin
                want = expected_results.pop_front();
                if (current_state !== want.state)
                begin
                    error_count++;
                    $display("%0t: current_state expected %0d actual %0d",
                             $time, want.state, current_state);
                end
                if (fired !== want.fired)
                begin
                    error_count++;
                    $display("%0t: fired expected %0d actual %0d",
                             $time, want.fired, fired);
                end
                if (status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                end
            end
        end
    end

    // After reset: state count 0 refuses every set, empty table never fires
    task automatic test_reset_behavior();
        send_word(tdsm_pkg::OP_SET, 8'h00, 8'h00, 8'h00);
        send_word(tdsm_pkg::OP_SET, 8'hFF, 8'hFF, 8'hFF);
        send_word(tdsm_pkg::OP_FIRE, 8'h00, 8'h00, 8'h00);
        send_word(tdsm_pkg::OP_FIRE, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF);
    endtask

    // Field extremes, first-match priority, no-match, range edges
    task automatic test_directed_transitions();
        write_state_count(9'd256);
        send_word(tdsm_pkg::OP_ADD, 8'h00, 8'hFF, 8'hFF);
        send_word(tdsm_pkg::OP_ADD, 8'hFF, 8'h00, 8'h00);
        send_word(tdsm_pkg::OP_ADD, 8'h00, 8'h07, 8'h05);
        send_word(tdsm_pkg::OP_ADD, 8'h00, 8'h09, 8'h05);   // shadowed by the entry above
        send_word(tdsm_pkg::OP_FIRE, 8'hAA, 8'h55, 8'hFF);  // 0 -> 255
        send_word(tdsm_pkg::OP_FIRE, 8'h55, 8'hAA, 8'h00);  // 255 -> 0
        send_word(tdsm_pkg::OP_FIRE, 8'h00, 8'h00, 8'h05);  // 0 -> 7, first match
        send_word(tdsm_pkg::OP_FIRE, 8'h00, 8'h00, 8'h05);  // no entry from 7
        send_word(OP_UNUSED, 8'h00, 8'h00, 8'h00);
        send_word(tdsm_pkg::OP_SET, 8'h00, 8'hFF, 8'h00);   // top of range accepted
        send_word(tdsm_pkg::OP_SET, 8'hFF, 8'h00, 8'hFF);
        write_state_count(9'd1);
        send_word(tdsm_pkg::OP_SET, 8'h00, 8'h00, 8'h00);
        send_word(tdsm_pkg::OP_SET, 8'h00, 8'h01, 8'h00);   // just out of range
        send_word(tdsm_pkg::OP_FIRE, 8'h00, 8'h00, 8'h05);
    endtask

    task automatic run_random_phase(input int n_items, input int add_pct);
        int r;
        for (int n = 0; n < n_items; n++)
        begin
            r = $urandom_range(99);
            if (r < add_pct)
                send_word(tdsm_pkg::OP_ADD, rand_field(), rand_field(), rand_field());
            else if (r < add_pct + 25)
            begin
                // bias set_state toward the edge of the defined range
                if (defined_states != 0 && $urandom_range(3) == 0)
                    send_word(tdsm_pkg::OP_SET, tdsm_pkg::FIELD_W'($urandom),
                              tdsm_pkg::FIELD_W'(defined_states - $urandom_range(1, 0)),
                              tdsm_pkg::FIELD_W'($urandom));
                else
                    send_word(tdsm_pkg::OP_SET, tdsm_pkg::FIELD_W'($urandom), rand_field(),
                              tdsm_pkg::FIELD_W'($urandom));
            end
            else if (r < 95)
                send_word(tdsm_pkg::OP_FIRE, tdsm_pkg::FIELD_W'($urandom),
                          tdsm_pkg::FIELD_W'($urandom), pick_fire_event());
            else
                send_word(OP_UNUSED, tdsm_pkg::FIELD_W'($urandom),
                          tdsm_pkg::FIELD_W'($urandom), tdsm_pkg::FIELD_W'($urandom));
        end
    endtask

    // Build most of the table while fires run over it
    task automatic test_random_fill();
        write_state_count(9'd16);
        gap_pct   = 30;
        stall_pct = 20;
        run_random_phase(90, 40);
    endtask

    task automatic test_table_full();
        while (tbl_count < DEPTH)
            send_word(tdsm_pkg::OP_ADD, rand_field(), rand_field(), rand_field());
        send_word(tdsm_pkg::OP_ADD, 8'hFF, 8'hFF, 8'hFF);
        send_word(tdsm_pkg::OP_ADD, 8'h00, 8'h00, 8'h00);
        send_word(tdsm_pkg::OP_ADD, tdsm_pkg::FIELD_W'($urandom), tdsm_pkg::FIELD_W'($urandom),
                  tdsm_pkg::FIELD_W'($urandom));
    endtask

    // Several state counts, extremes included, with varied idling
    task automatic test_random_mix();
        write_state_count(9'd256);
        gap_pct   = 0;
        stall_pct = 0;
        run_random_phase(60, 10);
        write_state_count(9'd0);
        gap_pct   = 40;
        stall_pct = 40;
        run_random_phase(40, 10);
        write_state_count(9'd255);
        gap_pct   = 15;
        stall_pct = 10;
        run_random_phase(60, 10);
        write_state_count(tdsm_pkg::STATE_CNT_W'($urandom_range(256)));
        gap_pct   = 50;
        stall_pct = 5;
        run_random_phase(60, 10);
        write_state_count(9'd16);
        gap_pct   = 5;
        stall_pct = 50;
        run_random_phase(50, 10);
    endtask

    // Receiver holds off while words keep coming, so the input backs up
    task automatic test_receiver_backpressure();
        write_state_count(9'd256);
        gap_pct      = 0;
        stall_pct    = 0;
        hold_request = 1'b1;
        run_random_phase(30, 5);
    endtask

    // Sender waits for the pipe to drain, then resumes
    task automatic test_sender_pause();
        wait_all_results();
        gap_pct   = 20;
        stall_pct = 20;
        run_random_phase(10, 5);
    endtask

    initial
    begin : main_sequence
        int drain;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        opcode         = tdsm_pkg::OP_ADD;
        from_state     = '0;
        to_state       = '0;
        event_code     = '0;
        hold_request   = 1'b0;
        gap_pct        = 20;
        stall_pct      = 20;
        error_count    = 0;
        tbl_count      = 0;
        fsm_state      = '0;
        defined_states = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_behavior();
        test_directed_transitions();
        test_random_fill();
        test_table_full();
        test_random_mix();
        test_receiver_backpressure();
        test_sender_pause();

        // drain, then let any stray word show up
        drain = 0;
        while (expected_results.size() != 0 && drain < 20000)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (DRAIN_WAIT) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected result words never arrived",
                     $time, expected_results.size());
        end
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
sv/tdsm_pkg.sv
sv/tdsm_ram.sv
sv/table_driven_state_machine_unit.sv
dv/testbench.sv
